// File: rtl/cocktail_shaker_sorter_top_defines.svh
// Assertion macros shared by the sorter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COCKTAIL_SHAKER_SORTER_TOP_DEFINES_SVH
`define COCKTAIL_SHAKER_SORTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked property, disabled while the asynchronous reset is active.
`define CSS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define CSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/css_pkg.sv
// Shared types for the cocktail shaker sorter: controller states,
// datapath operation codes and the status bundle. No dependencies.
package css_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [3:0] {
		S_LOAD,
		S_INIT,
		S_FPRIME,
		S_FCAP,
		S_FSTEP,
		S_FEND,
		S_BPRIME,
		S_BCAP,
		S_BSTEP,
		S_BEND,
		S_OINIT,
		S_ORD,
		S_OSHOW
	} css_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_INIT,
		DP_FPRIME,
		DP_FCAP,
		DP_FSTEP,
		DP_FEND,
		DP_BPRIME,
		DP_BCAP,
		DP_BSTEP,
		DP_BEND,
		DP_OINIT,
		DP_ORD,
		DP_ONEXT
	} css_op_t;

	typedef struct packed {
		logic load_close;   // this load closes the batch
		logic init_single;  // batch holds one element
		logic fstep_last;   // forward step reaches the right bound
		logic bstep_last;   // backward step reaches the left bound
		logic fwd_more;     // unsorted span remains after a forward pass
		logic bwd_more;     // unsorted span remains after a backward pass
		logic out_last;     // current output is the final one
	} css_status_t;

endpackage

// File: rtl/css_in_if.sv
// Input channel carrying one batch element per transaction.
// Depends on css_pkg for the data width.
interface css_in_if import css_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic                     is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink (input valid, input value, input is_last, output ready);
endinterface

// File: rtl/css_out_if.sv
// Output channel carrying one sorted element per transaction.
// Depends on css_pkg for the data width.
interface css_out_if import css_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     end_of_batch;

	modport source (output valid, output sorted_value, output end_of_batch, input ready);
	modport sink (input valid, input sorted_value, input end_of_batch, output ready);
endinterface

// File: rtl/css_ctrl.sv
// Sequencer for load, sort passes and readout of the sorter.
// Depends on css_pkg; drives css_datapath through op codes and reads its status.
module css_ctrl import css_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        out_ready,
	input  css_status_t status,
	output logic        in_ready,
	output logic        out_valid,
	output css_op_t     op
);

	css_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op        = DP_NOP;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = DP_LOAD;
					if (status.load_close)
						state_d = S_INIT;
				end
			end
			S_INIT: begin
				op      = DP_INIT;
				state_d = status.init_single ? S_OINIT : S_FPRIME;
			end
			S_FPRIME: begin
				op      = DP_FPRIME;
				state_d = S_FCAP;
			end
			S_FCAP: begin
				op      = DP_FCAP;
				state_d = S_FSTEP;
			end
			S_FSTEP: begin
				op = DP_FSTEP;
				if (status.fstep_last)
					state_d = S_FEND;
			end
			S_FEND: begin
				op      = DP_FEND;
				state_d = status.fwd_more ? S_BPRIME : S_OINIT;
			end
			S_BPRIME: begin
				op      = DP_BPRIME;
				state_d = S_BCAP;
			end
			S_BCAP: begin
				op      = DP_BCAP;
				state_d = S_BSTEP;
			end
			S_BSTEP: begin
				op = DP_BSTEP;
				if (status.bstep_last)
					state_d = S_BEND;
			end
			S_BEND: begin
				op      = DP_BEND;
				state_d = status.bwd_more ? S_FPRIME : S_OINIT;
			end
			S_OINIT: begin
				op      = DP_OINIT;
				state_d = S_ORD;
			end
			S_ORD: begin
				op      = DP_ORD;
				state_d = S_OSHOW;
			end
			S_OSHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					op      = DP_ONEXT;
					state_d = status.out_last ? S_LOAD : S_ORD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

// File: rtl/css_datapath.sv
// Element store, bounds, index and carry register of the sorter.
// Depends on css_pkg and the assertion macros; commanded by css_ctrl.
`include "cocktail_shaker_sorter_top_defines.svh"

module css_datapath import css_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  css_op_t                  op,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	output css_status_t              status,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     end_of_batch
);

	localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

	logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
	logic signed [DATA_W-1:0] rd_q;
	logic signed [DATA_W-1:0] carry_q;
	logic [CW-1:0]            count_q;
	logic [AW-1:0]            l_q, r_q, ls_q, i_q;

	logic                     we, re;
	logic [AW-1:0]            wa, ra;
	logic signed [DATA_W-1:0] wd;
	logic                     out_last;
	logic                     fwd_swap, bwd_swap;

	assign out_last = (CW'(i_q) == (count_q - CW'(1)));
	// carry is the value travelling with the pass; a swap keeps it moving
	assign fwd_swap = (carry_q < rd_q);
	assign bwd_swap = (carry_q > rd_q);

	always_comb begin
		status.load_close  = is_last || (count_q == CW'(MAX_ELEMENTS - 1));
		status.init_single = (count_q == CW'(1));
		status.fstep_last  = (AW'(i_q + AW'(1)) == r_q);
		status.bstep_last  = (i_q == AW'(l_q + AW'(1)));
		status.fwd_more    = (ls_q > l_q);
		status.bwd_more    = (ls_q < r_q);
		status.out_last    = out_last;
	end

	assign sorted_value = rd_q;
	assign end_of_batch = out_last;

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = i_q;
		ra = i_q;
		wd = carry_q;
		case (op)
			DP_LOAD: begin
				we = 1'b1;
				wa = count_q[AW-1:0];
				wd = value;
			end
			DP_FPRIME: begin
				re = 1'b1;
				ra = l_q;
			end
			DP_FCAP: begin
				re = 1'b1;
				ra = AW'(i_q + AW'(1));
			end
			DP_FSTEP: begin
				re = 1'b1;
				ra = AW'(i_q + AW'(2));
				we = 1'b1;
				wd = fwd_swap ? rd_q : carry_q;
			end
			DP_FEND: begin
				we = 1'b1;
				wa = r_q;
			end
			DP_BPRIME: begin
				re = 1'b1;
				ra = r_q;
			end
			DP_BCAP: begin
				re = 1'b1;
				ra = AW'(i_q - AW'(1));
			end
			DP_BSTEP: begin
				re = 1'b1;
				ra = AW'(i_q - AW'(2));
				we = 1'b1;
				wd = bwd_swap ? rd_q : carry_q;
			end
			DP_BEND: begin
				we = 1'b1;
				wa = l_q;
			end
			DP_ORD: begin
				re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		case (op)
			DP_FCAP, DP_BCAP: carry_q <= rd_q;
			DP_FSTEP: begin
				if (!fwd_swap)
					carry_q <= rd_q;
			end
			DP_BSTEP: begin
				if (!bwd_swap)
					carry_q <= rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			l_q     <= '0;
			r_q     <= '0;
			ls_q    <= '0;
			i_q     <= '0;
		end else begin
			case (op)
				DP_LOAD: count_q <= count_q + CW'(1);
				DP_INIT: begin
					l_q <= '0;
					r_q <= AW'(count_q - CW'(1));
				end
				DP_FPRIME: begin
					i_q  <= l_q;
					ls_q <= l_q;
				end
				DP_FSTEP: begin
					if (fwd_swap)
						ls_q <= i_q;
					i_q <= AW'(i_q + AW'(1));
				end
				DP_FEND: r_q <= ls_q;
				DP_BPRIME: begin
					i_q  <= r_q;
					ls_q <= r_q;
				end
				DP_BSTEP: begin
					if (bwd_swap)
						ls_q <= i_q;
					i_q <= AW'(i_q - AW'(1));
				end
				DP_BEND: l_q <= ls_q;
				DP_OINIT: i_q <= '0;
				DP_ONEXT: begin
					if (out_last)
						count_q <= '0;
					else
						i_q <= AW'(i_q + AW'(1));
				end
				default: begin
				end
			endcase
		end
	end

	`CSS_ASSERT(a_fstep_in_span, clk, arst_n, (op == DP_FSTEP) |-> (i_q >= l_q && i_q < r_q), "forward step outside bounds")
	`CSS_ASSERT(a_bstep_in_span, clk, arst_n, (op == DP_BSTEP) |-> (i_q > l_q && i_q <= r_q), "backward step outside bounds")
	`CSS_ASSERT(a_right_shrinks, clk, arst_n, (op == DP_FEND) |=> (r_q < $past(r_q)), "right bound did not shrink")
	`CSS_ASSERT(a_left_grows, clk, arst_n, (op == DP_BEND) |=> (l_q > $past(l_q)), "left bound did not grow")
	`CSS_ASSERT(a_count_range, clk, arst_n, (count_q <= CW'(MAX_ELEMENTS)), "element count overflow")

endmodule

// File: rtl/cocktail_shaker_sorter_top.sv
// Cocktail shaker sorter: accepts a batch of up to MAX_ELEMENTS signed 32-bit
// values, one per cycle, until a transaction with is_last set or until the store
// is full, then sorts the batch in place into descending order and returns it one
// transaction per element, end_of_batch on the final one. No input is taken while
// a batch is sorted or read out. Each sort pass runs a read prime, a carry capture,
// a compare step per adjacent pair of its span and a final write, because
// the store has one write and one registered read port; passes alternate
// direction and shrink to the last swap, and a batch already in descending
// order needs only one forward pass. Readout reads each element through the
// registered store read before it is offered on the output.
// No clearing pass after reset.
// Depends on css_pkg, css_in_if, css_out_if, css_ctrl and css_datapath.
module cocktail_shaker_sorter_top import css_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input logic      clk,
	input logic      arst_n,
	css_in_if.sink   elem,
	css_out_if.source result
);

	css_op_t     op;
	css_status_t status;

	css_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (elem.valid),
		.out_ready (result.ready),
		.status    (status),
		.in_ready  (elem.ready),
		.out_valid (result.valid),
		.op        (op)
	);

	css_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.value        (elem.value),
		.is_last      (elem.is_last),
		.status       (status),
		.sorted_value (result.sorted_value),
		.end_of_batch (result.end_of_batch)
	);

endmodule
